[src/pmat_pkg.sv]
// Shared types and constants for the pulse meter with automatic threshold.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pmat_pkg;

  // Sensor sample width.
  localparam int SAMPLE_BITS = 10;

  // Field and register widths.
  localparam int WINDOW_BITS    = 17;
  localparam int PPU_BITS       = 10;
  localparam int ENERGY_BITS    = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 17;

  // Register reset values.
  localparam logic [SAMPLE_BITS-1:0] ARM_RESET    = SAMPLE_BITS'(150);
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(65000);
  localparam logic [PPU_BITS-1:0]    PPU_RESET    = PPU_BITS'(500);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_ARM_LEVEL       = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_TICKS    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PULSES_PER_UNIT = 2'd2;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] arm_level;
    logic [WINDOW_BITS-1:0] window_ticks;
    logic [PPU_BITS-1:0]    pulses_per_unit;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic [ENERGY_BITS-1:0] energy_units;
    logic                   calibrated;
    logic [SAMPLE_BITS-1:0] level_threshold;
  } res_t;

endpackage

`default_nettype wire

[src/pulse_meter_auto_threshold.sv]
// Top level of the pulse meter with automatic threshold: input register,
// output register and the config and core modules. Depends on pmat_pkg,
// pmat_cfg and pmat_core.
//
//   Channel   Handshake              Word
//   input     in_valid / in_ready    kind, sample
//   result    out_valid / out_ready  energy_units, calibrated, level_threshold
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per cycle is accepted while the result side is not stalled. Each word
// is held in the input register, and its result is then held in the result register
// until it is taken.
// Reset is synchronous; it sets the valid flags, config and meter state, not the data.
// A stalled result holds both registers; the input side stays ready while
// the input register is empty. Config writes are taken in every cycle.
`default_nettype none

module pulse_meter_auto_threshold
  import pmat_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      kind,
  input  logic [SAMPLE_BITS-1:0]    sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ENERGY_BITS-1:0]    energy_units,
  output logic                      calibrated,
  output logic [SAMPLE_BITS-1:0]    level_threshold,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t                   cfg;
  res_t                   res;
  logic                   stage_valid;
  logic                   stage_kind;
  logic [SAMPLE_BITS-1:0] stage_sample;
  logic                   advance;

  // The pipeline moves when the result register is free or being taken.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !stage_valid || advance;

  pmat_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pmat_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (stage_valid && advance),
    .kind       (stage_kind),
    .sample     (stage_sample),
    .cfg        (cfg),
    .res        (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage_kind   <= kind;
      stage_sample <= sample;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
    if (advance && stage_valid) begin
      energy_units    <= res.energy_units;
      calibrated      <= res.calibrated;
      level_threshold <= res.level_threshold;
    end
  end

endmodule

`default_nettype wire

[src/pmat_cfg.sv]
// Configuration register file for the pulse meter.
// Depends on pmat_pkg for widths, indexes and reset values.
`default_nettype none

module pmat_cfg
  import pmat_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                      cfg
);

  // Writes are always taken; an index past the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arm_level       <= ARM_RESET;
      cfg.window_ticks    <= WINDOW_RESET;
      cfg.pulses_per_unit <= PPU_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ARM_LEVEL:       cfg.arm_level       <= cfg_data[SAMPLE_BITS-1:0];
        REG_WINDOW_TICKS:    cfg.window_ticks    <= cfg_data[WINDOW_BITS-1:0];
        REG_PULSES_PER_UNIT: cfg.pulses_per_unit <= cfg_data[PPU_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/pmat_core.sv]
// Meter state and its one-word update: arming, calibration window,
// threshold midpoint, pulse detection and energy counting.
// Depends on pmat_pkg.
`default_nettype none

module pmat_core
  import pmat_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic                   kind,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  cfg_t                   cfg,
  output res_t                   res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CAL  = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  phase_t                 phase, phase_next;
  logic [SAMPLE_BITS-1:0] low_seen, low_seen_next;
  logic [SAMPLE_BITS-1:0] high_seen, high_seen_next;
  logic [WINDOW_BITS-1:0] window_left, window_left_next;
  logic [SAMPLE_BITS-1:0] detect_level, detect_level_next;
  logic                   above_flag, above_flag_next;
  logic [PPU_BITS-1:0]    pulse_count, pulse_count_next;
  logic [ENERGY_BITS-1:0] energy_count, energy_count_next;

  logic [SAMPLE_BITS:0]   mid_sum;
  logic [PPU_BITS-1:0]    pulse_tmp;

  assign mid_sum = {1'b0, low_seen} + {1'b0, high_seen};

  // Next state for the word in the input register.
  always_comb begin
    phase_next        = phase;
    low_seen_next     = low_seen;
    high_seen_next    = high_seen;
    window_left_next  = window_left;
    detect_level_next = detect_level;
    above_flag_next   = above_flag;
    pulse_count_next  = pulse_count;
    energy_count_next = energy_count;
    pulse_tmp         = pulse_count;
    case (phase)
      PH_CAL: begin
        if (kind) begin
          // A tick counts the window down; the last one sets the threshold.
          if (window_left <= WINDOW_BITS'(1)) begin
            window_left_next  = '0;
            detect_level_next = mid_sum[SAMPLE_BITS:1];
            phase_next        = PH_DONE;
          end else begin
            window_left_next = window_left - WINDOW_BITS'(1);
          end
        end else if (sample < low_seen) begin
          low_seen_next = sample;
        end else if (sample > high_seen) begin
          high_seen_next = sample;
        end
      end
      PH_DONE: begin
        if (!kind) begin
          // Rising crossing counts a pulse; a full count adds one unit.
          if (sample > detect_level) begin
            if (!above_flag) begin
              above_flag_next = 1'b1;
              pulse_tmp       = pulse_count + PPU_BITS'(1);
            end
          end else begin
            above_flag_next = 1'b0;
          end
          if (pulse_tmp >= cfg.pulses_per_unit) begin
            energy_count_next = energy_count + ENERGY_BITS'(1);
            pulse_tmp         = '0;
          end
          pulse_count_next = pulse_tmp;
        end
      end
      default: begin
        // Idle or an unused code: a bright sample starts calibration.
        if (!kind && (sample > cfg.arm_level)) begin
          low_seen_next    = sample;
          high_seen_next   = sample;
          window_left_next = cfg.window_ticks;
          phase_next       = PH_CAL;
        end
      end
    endcase
  end

  // State registers, updated once per word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      low_seen     <= '0;
      high_seen    <= '0;
      window_left  <= '0;
      detect_level <= '0;
      above_flag   <= 1'b0;
      pulse_count  <= PPU_RESET;
      energy_count <= '0;
    end else if (item_valid) begin
      phase        <= phase_next;
      low_seen     <= low_seen_next;
      high_seen    <= high_seen_next;
      window_left  <= window_left_next;
      detect_level <= detect_level_next;
      above_flag   <= above_flag_next;
      pulse_count  <= pulse_count_next;
      energy_count <= energy_count_next;
    end
  end

  // The result shows the state after this word.
  assign res.energy_units    = energy_count_next;
  assign res.calibrated      = (phase_next == PH_DONE);
  assign res.level_threshold = detect_level_next;

endmodule

`default_nettype wire

[src/pmat_checker.sv]
// Port-level checks for the pulse meter, bound to the top level.
// Depends on pmat_pkg for widths.
`default_nettype none

module pmat_checker
  import pmat_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [ENERGY_BITS-1:0] energy_units,
  input logic                   calibrated,
  input logic [SAMPLE_BITS-1:0] level_threshold
);

  logic                   seen_word;
  logic                   seen_cal;
  logic [ENERGY_BITS-1:0] last_energy;
  logic [SAMPLE_BITS-1:0] last_threshold;

  // Remember what the last taken result word showed.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_word <= 1'b0;
      seen_cal  <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_word <= 1'b1;
      seen_cal  <= seen_cal || calibrated;
    end
    if (out_valid && out_ready) begin
      last_energy    <= energy_units;
      last_threshold <= level_threshold;
    end
  end

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(energy_units)
      && $stable(calibrated) && $stable(level_threshold))
    else $error("result word changed while stalled");

  // Calibration never goes away.
  a_cal_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_cal |-> calibrated)
    else $error("calibrated dropped");

  // The threshold is fixed once calibrated and zero before.
  a_thr_fixed: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_cal |-> level_threshold == last_threshold)
    else $error("threshold changed after calibration");

  a_thr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !calibrated |-> level_threshold == '0)
    else $error("threshold set before calibration");

  // Each word adds at most one energy unit.
  a_energy_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_word |->
      energy_units == last_energy || energy_units == last_energy + ENERGY_BITS'(1))
    else $error("energy count jumped");

endmodule

bind pulse_meter_auto_threshold pmat_checker u_pmat_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .energy_units    (energy_units),
  .calibrated      (calibrated),
  .level_threshold (level_threshold)
);

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for pulse_meter_auto_threshold: directed table, then random
// pulse trains under four idle patterns; typed rows expect an all-zero word, the rest
// the in-bench meter model. Depends on pmat_pkg and the RTL of the block.

module tb;
  import pmat_pkg::*;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          RESET_CYCLES = 4;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          RAND_PHASES  = 8;
  localparam int          PHASE_WORDS  = 135;
  localparam logic        KIND_SAMPLE  = 1'b0;
  localparam logic        KIND_TICK    = 1'b1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;
  localparam logic [SAMPLE_BITS-1:0]    SAMPLE_MAX = '1;
  localparam res_t        IDLE_WORD    = '0;

  typedef enum logic [1:0] {
    MTR_IDLE        = 2'd0,
    MTR_CALIBRATING = 2'd1,
    MTR_CALIBRATED  = 2'd2
  } meter_phase_t;

  // One row of the directed table: a register write or an input word.
  typedef struct {
    bit                         is_write;
    logic [CFG_INDEX_BITS-1:0]  index;
    logic                       kind;
    logic [CFG_DATA_BITS-1:0]   value;
    bit                         typed;
    res_t                       want;
  } plan_row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic [SAMPLE_BITS-1:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ENERGY_BITS-1:0] energy_units;
  logic calibrated;
  logic [SAMPLE_BITS-1:0] level_threshold;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Meter model state and its copy of the registers.
  meter_phase_t           mtr_phase;
  logic [SAMPLE_BITS-1:0] mtr_low, mtr_high, mtr_level;
  logic [WINDOW_BITS-1:0] mtr_window_left;
  logic                   mtr_above;
  logic [PPU_BITS-1:0]    mtr_pulses;
  logic [ENERGY_BITS-1:0] mtr_energy;
  logic [SAMPLE_BITS-1:0] mtr_arm;
  logic [WINDOW_BITS-1:0] mtr_window;
  logic [PPU_BITS-1:0]    mtr_ppu;

  res_t        expected_readings[$];
  plan_row_t   plan[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;

  pulse_meter_auto_threshold i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .sample          (sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .energy_units    (energy_units),
    .calibrated      (calibrated),
    .level_threshold (level_threshold),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Advance the meter model by one input word and return the reading it shows.
  task automatic predict_reading(input logic k, input logic [SAMPLE_BITS-1:0] s,
                                 output res_t r);
    if (k == KIND_TICK) begin
      if (mtr_phase == MTR_CALIBRATING) begin
        if (mtr_window_left <= WINDOW_BITS'(1)) begin
          mtr_window_left = '0;
          mtr_level = SAMPLE_BITS'(({1'b0, mtr_low} + {1'b0, mtr_high}) >> 1);
          mtr_phase = MTR_CALIBRATED;
        end else begin
          mtr_window_left = mtr_window_left - 1'b1;
        end
      end
    end else begin
      case (mtr_phase)
        MTR_CALIBRATING: begin
          if (s < mtr_low) mtr_low = s;
          else if (s > mtr_high) mtr_high = s;
        end
        MTR_CALIBRATED: begin
          // A rising crossing counts one pulse; a full count books one unit.
          if (s > mtr_level) begin
            if (!mtr_above) begin
              mtr_above = 1'b1;
              mtr_pulses = mtr_pulses + 1'b1;
            end
          end else begin
            mtr_above = 1'b0;
          end
          if (mtr_pulses >= mtr_ppu) begin
            mtr_energy = mtr_energy + 1'b1;
            mtr_pulses = '0;
          end
        end
        default: begin
          if (s > mtr_arm) begin
            mtr_low = s;
            mtr_high = s;
            mtr_window_left = mtr_window;
            mtr_phase = MTR_CALIBRATING;
          end
        end
      endcase
    end
    r.energy_units = mtr_energy;
    r.calibrated = (mtr_phase == MTR_CALIBRATED);
    r.level_threshold = mtr_level;
  endtask

  // Present one input word, wait for it to be taken and queue its reading.
  task automatic send_word(input logic k, input logic [SAMPLE_BITS-1:0] s,
                           input bit typed, input res_t want);
    res_t predicted;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    sample <= s;
    do @(posedge clk); while (!in_ready);
    predict_reading(k, s, predicted);
    expected_readings.push_back(typed ? want : predicted);
  endtask

  // Write one register; the model takes the value once the word is accepted.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ARM_LEVEL:       mtr_arm = data[SAMPLE_BITS-1:0];
      REG_WINDOW_TICKS:    mtr_window = data[WINDOW_BITS-1:0];
      REG_PULSES_PER_UNIT: mtr_ppu = data[PPU_BITS-1:0];
      default: ;
    endcase
  endtask

  // Stop sending and wait until every queued reading has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic plan_row_t write_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                          input logic [CFG_DATA_BITS-1:0] data);
    plan_row_t row;
    row = '{is_write: 1'b1, index: idx, kind: KIND_SAMPLE, value: data,
            typed: 1'b0, want: IDLE_WORD};
    return row;
  endfunction

  function automatic plan_row_t word_row(input logic k, input int s, input bit typed);
    plan_row_t row;
    row = '{is_write: 1'b0, index: REG_SPARE, kind: k, value: CFG_DATA_BITS'(s),
            typed: typed, want: IDLE_WORD};
    return row;
  endfunction

  // Result side: random stalls and the field-by-field comparison.
  always @(posedge clk) begin
    res_t want;
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $error("result word arrived with no expectation pending");
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        if (energy_units !== want.energy_units) begin
          $error("energy_units: expected %0d, got %0d", want.energy_units, energy_units);
          mismatches++;
        end
        if (calibrated !== want.calibrated) begin
          $error("calibrated: expected %0d, got %0d", want.calibrated, calibrated);
          mismatches++;
        end
        if (level_threshold !== want.level_threshold) begin
          $error("level_threshold: expected %0d, got %0d",
                 want.level_threshold, level_threshold);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int                     cal_window;
    int                     pick;
    int                     thr;
    int                     ppu_value;
    bit                     go_high;
    logic [SAMPLE_BITS-1:0] s;

    mtr_phase = MTR_IDLE;
    mtr_low = '0;
    mtr_high = '0;
    mtr_level = '0;
    mtr_window_left = '0;
    mtr_above = 1'b0;
    mtr_pulses = PPU_RESET;
    mtr_energy = '0;
    mtr_arm = ARM_RESET;
    mtr_window = WINDOW_RESET;
    mtr_ppu = PPU_RESET;

    // A short window, zero included, so the single-tick path or the countdown path occurs.
    cal_window = $urandom_range(0, 3);

    // Idle words: ticks ignored, the arming level is a strict compare.
    plan.push_back(word_row(KIND_TICK, 0, 1'b1));
    plan.push_back(word_row(KIND_SAMPLE, 150, 1'b1));
    plan.push_back(word_row(KIND_SAMPLE, 0, 1'b1));
    // Upper data bits are dropped, so the level becomes the largest sample.
    plan.push_back(write_row(REG_ARM_LEVEL, 17'h1FFFF));
    plan.push_back(word_row(KIND_SAMPLE, SAMPLE_MAX, 1'b1));
    // A write to the unused index must not touch the arming level.
    plan.push_back(write_row(REG_SPARE, '0));
    plan.push_back(word_row(KIND_SAMPLE, SAMPLE_MAX, 1'b1));
    plan.push_back(write_row(REG_WINDOW_TICKS, 17'h1FFFF));
    plan.push_back(write_row(REG_WINDOW_TICKS, CFG_DATA_BITS'(cal_window)));
    plan.push_back(write_row(REG_ARM_LEVEL, '0));
    plan.push_back(word_row(KIND_SAMPLE, 0, 1'b1));
    // Calibration seeds on this sample, then the extremes widen the range.
    plan.push_back(word_row(KIND_SAMPLE, 1, 1'b1));
    plan.push_back(word_row(KIND_SAMPLE, SAMPLE_MAX, 1'b1));
    plan.push_back(word_row(KIND_SAMPLE, 0, 1'b1));
    plan.push_back(word_row(KIND_TICK, 0, 1'b0));
    plan.push_back(word_row(KIND_SAMPLE, 300, 1'b0));
    plan.push_back(word_row(KIND_TICK, SAMPLE_MAX, 1'b0));
    plan.push_back(word_row(KIND_TICK, 0, 1'b0));
    plan.push_back(word_row(KIND_TICK, 0, 1'b0));
    // First calibrated sample books a unit from the preset count; then the threshold edge.
    plan.push_back(word_row(KIND_SAMPLE, SAMPLE_MAX, 1'b0));
    plan.push_back(word_row(KIND_SAMPLE, 511, 1'b0));
    plan.push_back(word_row(KIND_SAMPLE, 512, 1'b0));
    // With zero pulses per unit every sample books a unit.
    plan.push_back(write_row(REG_PULSES_PER_UNIT, '0));
    plan.push_back(word_row(KIND_SAMPLE, 0, 1'b0));
    plan.push_back(word_row(KIND_SAMPLE, 0, 1'b0));
    plan.push_back(write_row(REG_PULSES_PER_UNIT, 17'd1000));
    plan.push_back(word_row(KIND_SAMPLE, SAMPLE_MAX, 1'b0));
    plan.push_back(word_row(KIND_SAMPLE, 0, 1'b0));
    plan.push_back(word_row(KIND_SAMPLE, SAMPLE_MAX, 1'b0));
    plan.push_back(word_row(KIND_SAMPLE, 0, 1'b0));
    plan.push_back(word_row(KIND_SAMPLE, SAMPLE_MAX, 1'b0));
    // Lowering the per-unit count below the running count books a unit at once.
    plan.push_back(write_row(REG_PULSES_PER_UNIT, 17'd2));
    plan.push_back(word_row(KIND_SAMPLE, 0, 1'b0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        settle();
        write_reg(plan[i].index, plan[i].value);
      end else begin
        send_word(plan[i].kind, plan[i].value[SAMPLE_BITS-1:0], plan[i].typed, plan[i].want);
      end
    end

    // Random pulse trains, one register setting and idle pattern per phase.
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      send_gap_pct = 0;
      recv_stall_pct = 0;
      write_reg(REG_ARM_LEVEL, CFG_DATA_BITS'($urandom_range(0, 1023)));
      settle();
      write_reg(REG_WINDOW_TICKS, CFG_DATA_BITS'($urandom_range(0, 131071)));
      settle();
      case (p)
        0: ppu_value = 1;
        3: ppu_value = 1000;
        5: ppu_value = 0;
        default: ppu_value = $urandom_range(1, 6);
      endcase
      write_reg(REG_PULSES_PER_UNIT, CFG_DATA_BITS'(ppu_value));
      case (p % 4)
        1: send_gap_pct = 75;
        2: recv_stall_pct = 75;
        3: begin
          send_gap_pct = 19;
          recv_stall_pct = 19;
        end
        default: ;
      endcase

      repeat (PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        thr = int'(mtr_level);
        s = SAMPLE_BITS'($urandom);
        if (pick >= 75 && pick < 88) begin
          send_word(KIND_TICK, s, 1'b0, IDLE_WORD);
        end else if (pick >= 88 || thr == int'(SAMPLE_MAX)) begin
          send_word(KIND_SAMPLE, s, 1'b0, IDLE_WORD);
        end else begin
          // Mostly alternate across the threshold, sometimes repeat the same side.
          go_high = (pick < 60) ? !mtr_above : mtr_above;
          if (go_high) s = SAMPLE_BITS'($urandom_range(thr + 1, int'(SAMPLE_MAX)));
          else s = SAMPLE_BITS'($urandom_range(0, thr));
          send_word(KIND_SAMPLE, s, 1'b0, IDLE_WORD);
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
src/pmat_pkg.sv
src/pmat_cfg.sv
src/pmat_core.sv
src/pulse_meter_auto_threshold.sv
src/pmat_checker.sv
sim/tb.sv
